[sv/sorted_vector_nearest_lookup_top_macros.svh]
// Assertion macros for the sorted vector nearest lookup block.
// Included by the top level; bodies vanish when SYNTH is defined.
`ifndef SORTED_VECTOR_NEAREST_LOOKUP_TOP_MACROS_SVH
`define SORTED_VECTOR_NEAREST_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTH
`define SVNL_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define SVNL_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define SVNL_ASSERT_IMPL(label, clk, rst, prop)
`define SVNL_ASSERT_NORST(label, clk, prop)
`endif
`endif

[sv/svnl_pkg.sv]
// Package for the sorted vector nearest lookup block: sizes, codes and types
// shared by the lane, merge and top-level modules. No dependencies.
`timescale 1ns / 1ps
package svnl_pkg;
   localparam int MAX_ROWS_DEF    = 1024;
   localparam int MAX_VARS_DEF    = 4;
   localparam int LINEAR_SPAN_DEF = 12;
   localparam int VAL_W   = 32;
   localparam int ROW_W   = 10;
   localparam int VAR_W   = 2;
   localparam int CFG_W   = 3;
   localparam int NQ      = 4;

   typedef enum logic [1:0] {
      OP_STORE  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [0:0] REG_VARS_IN_USE = 1'b0;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SORT_RD_I,
      ST_SORT_WAIT_I,
      ST_SORT_RD_J,
      ST_SORT_WAIT_J,
      ST_SORT_CMP_J,
      ST_SORT_PLACE,
      ST_CLAMP,
      ST_RD,
      ST_WAIT,
      ST_EVAL,
      ST_DONE
   } state_type;

   // Phases of one lookup
   typedef enum logic [2:0] {
      PH_FIRST,
      PH_LAST,
      PH_BIN_BOT,
      PH_BIN_TOP,
      PH_BIN_MID,
      PH_LIN,
      PH_NEAR
   } phase_type;

   // Per-lane comparison result
   typedef struct packed {
      logic gt;   // a > b
      logic lt;   // a < b
   } cmp_type;
endpackage

[sv/svnl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module svnl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/svnl_lane.sv]
// One coordinate lane: signed compare and absolute difference of a row value
// against a reference value. Uses svnl_pkg.
`timescale 1ns / 1ps
module svnl_lane (
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output svnl_pkg::cmp_type  cmp,
   output logic [32:0]        abs_diff
);
   import svnl_pkg::*;
   logic signed [32:0] diff;

   always_comb begin
      diff     = 33'(a) - 33'(b);
      cmp.gt   = a > b;
      cmp.lt   = a < b;
      abs_diff = diff[32] ? 33'(-diff) : 33'(diff);
   end
endmodule

[sv/svnl_merge.sv]
// Merge stage: folds per-lane compare results into a lexicographic order
// over the lanes in use, and picks the first lane that differs. Uses svnl_pkg.
`timescale 1ns / 1ps
module svnl_merge #(
   parameter int MAX_VARS = svnl_pkg::MAX_VARS_DEF
) (
   input  svnl_pkg::cmp_type         cmp  [MAX_VARS],
   input  logic [32:0]               du   [MAX_VARS],
   input  logic [32:0]               dl   [MAX_VARS],
   input  logic [$clog2(MAX_VARS+1)-1:0] nv,
   output svnl_pkg::cmp_type         order,
   output logic                      upper_nearer
);
   import svnl_pkg::*;
   logic decided;
   logic ddone;

   always_comb begin
      order        = '0;
      decided      = 1'b0;
      upper_nearer = 1'b0;
      ddone        = 1'b0;
      for (int i = 0; i < MAX_VARS; i++) begin
         if (i < int'(nv) && !decided && (cmp[i].gt || cmp[i].lt)) begin
            order   = cmp[i];
            decided = 1'b1;
         end
         // first coordinate where either row differs from the query
         if (i < int'(nv) && !ddone && (du[i] != '0 || dl[i] != '0)) begin
            upper_nearer = du[i] < dl[i];
            ddone        = 1'b1;
         end
      end
   end
endmodule

[sv/sorted_vector_nearest_lookup_top.sv]
// Sorted vector table with nearest-row lookup: two lanes per coordinate and two
// merge stages. Uses svnl_pkg, svnl_ram, svnl_lane, svnl_merge and the macro header.
//
// Usage: req_ carries store, lookup and clear items; rsp_ returns one result
// per lookup (chosen_row, table_empty). csr_ is an APB port with vars_in_use
// at address 0; writing it empties the table.
// The first lookup after a store runs an insertion sort over the rows through
// the row memories. A lookup then clamps the query and makes memory probes, each
// through the RD, WAIT and EVAL states: edge probes of the first and last rows,
// equality probes of both bounds and a midpoint probe per halving step, and up
// to LINEAR_SPAN+1 linear probes plus a pair check after a linear scan, and then
// posts the result. One item is worked on at a time; the memory read port sets the pace.
// Reset empties the table at once (row count, extremes, sorted flag) with no
// clearing pass; row memories hold unwritten data until stored.
// A finished result sits in an output register; while the receiver stalls,
// the block holds it and accepts no new item.
`timescale 1ns / 1ps
`include "sorted_vector_nearest_lookup_top_macros.svh"
module sorted_vector_nearest_lookup_top #(
   parameter int MAX_ROWS    = svnl_pkg::MAX_ROWS_DEF,
   parameter int MAX_VARS    = svnl_pkg::MAX_VARS_DEF,
   parameter int LINEAR_SPAN = svnl_pkg::LINEAR_SPAN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [9:0] row_number, [11:10] coordinate_number, [43:12] coordinate_value,
   // [75:44] query_0, [107:76] query_1, [139:108] query_2,
   // [171:140] query_3, [175:172] zero
   input  logic [175:0] req_tdata,
   // [1:0] operation
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [9:0] chosen_row, [15:10] zero
   output logic [15:0]  rsp_tdata,
   // [0] table_empty
   output logic         rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import svnl_pkg::*;
   localparam int AW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_ROWS + 1);
   localparam int NVW = $clog2(MAX_VARS + 1);
   localparam int DW  = MAX_VARS * VAL_W;
   localparam int QL  = (MAX_VARS < NQ) ? MAX_VARS : NQ;

   // request fields
   op_type             op;
   logic [ROW_W-1:0]   row_number;
   logic [VAR_W-1:0]   coord_number;
   logic signed [31:0] coord_value;
   logic signed [31:0] query [NQ];

   assign op           = op_type'(req_tuser);
   assign row_number   = req_tdata[9:0];
   assign coord_number = req_tdata[11:10];
   assign coord_value  = req_tdata[43:12];
   always_comb begin
      for (int i = 0; i < NQ; i++) query[i] = req_tdata[44 + 32*i +: 32];
   end

   // state
   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [CFG_W-1:0]   vars_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic               sorted_ff, sorted_in;
   logic signed [31:0] least_ff [MAX_VARS];
   logic signed [31:0] great_ff [MAX_VARS];
   logic signed [31:0] cq_ff [MAX_VARS];
   logic signed [31:0] qin_ff [MAX_VARS];
   logic [AW-1:0]      i_ff, i_in, j_ff, j_in;
   logic [AW-1:0]      bot_ff, bot_in, top_ff, top_in;
   logic [DW-1:0]      tmp_ff, tmp_in;
   logic [ROW_W-1:0]   tmptag_ff, tmptag_in;
   logic [DW-1:0]      prev_ff, prev_in;     // lower row of a pair
   logic [ROW_W-1:0]   prevtag_ff, prevtag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]   rsp_row_ff, rsp_row_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic [NVW-1:0]     nv;

   // memory ports
   logic               we;
   logic [AW-1:0]      waddr, raddr;
   logic [DW-1:0]      wdata_v, rdata_v;
   logic [ROW_W-1:0]   wdata_t, rdata_t;
   logic [MAX_VARS-1:0] we_lane;

   genvar g;
   generate
      for (g = 0; g < MAX_VARS; g++) begin : g_vram
         svnl_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_vram (
            .clock(clock), .we(we_lane[g]), .waddr(waddr),
            .wdata(wdata_v[g*VAL_W +: VAL_W]), .raddr(raddr),
            .rdata(rdata_v[g*VAL_W +: VAL_W]));
      end
   endgenerate
   svnl_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_tram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata_t),
      .raddr(raddr), .rdata(rdata_t));

   // lanes: A compares rdata against a reference (tmp or clamped query);
   // B gives distance of lower row (prev) for nearness.
   logic               sort_mode;
   cmp_type            cmp_a [MAX_VARS];
   cmp_type            cmp_b [MAX_VARS];
   logic [32:0]        du [MAX_VARS];
   logic [32:0]        dl [MAX_VARS];
   logic signed [31:0] ref_v [MAX_VARS];
   cmp_type            ord;
   cmp_type            ord_unused;
   logic               upper_nearer, unused_near;

   always_comb begin
      for (int i = 0; i < MAX_VARS; i++)
         ref_v[i] = sort_mode ? tmp_ff[i*VAL_W +: VAL_W] : cq_ff[i];
   end

   generate
      for (g = 0; g < MAX_VARS; g++) begin : g_lane
         svnl_lane u_a (.a(rdata_v[g*VAL_W +: VAL_W]), .b(ref_v[g]),
                        .cmp(cmp_a[g]), .abs_diff(du[g]));
         svnl_lane u_b (.a(prev_ff[g*VAL_W +: VAL_W]), .b(cq_ff[g]),
                        .cmp(cmp_b[g]), .abs_diff(dl[g]));
      end
   endgenerate

   svnl_merge #(.MAX_VARS(MAX_VARS)) u_merge (
      .cmp(cmp_a), .du(du), .dl(dl), .nv(nv), .order(ord),
      .upper_nearer(upper_nearer));
   svnl_merge #(.MAX_VARS(MAX_VARS)) u_merge_b (
      .cmp(cmp_b), .du(dl), .dl(dl), .nv(nv), .order(ord_unused),
      .upper_nearer(unused_near));

   // ord: row (rdata) vs reference. row > ref is ord.gt; query above row is ord.lt
   logic row_gt, q_above, q_equal;
   assign row_gt  = ord.gt;
   assign q_above = ord.lt;
   assign q_equal = !ord.gt && !ord.lt;

   always_comb begin
      if (vars_ff == '0) nv = NVW'(1);
      else if (int'(vars_ff) > MAX_VARS) nv = NVW'(MAX_VARS);
      else nv = NVW'(vars_ff);
   end

   // csr
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr == 2'(REG_VARS_IN_USE)) ? 32'(vars_ff) : '0;

   logic acc, store_ok, do_clear;
   logic [AW:0] span;
   logic [AW:0] mid_sum;
   logic [AW-1:0] mid;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign acc        = req_tvalid && req_tready;
   assign store_ok   = acc && op == OP_STORE && (32'(coord_number) < 32'(nv))
                       && (32'(row_number) < 32'(MAX_ROWS));
   assign do_clear   = (csr_wr && csr_paddr == 2'(REG_VARS_IN_USE))
                       || (acc && op == OP_CLEAR);
   assign span       = {1'b0, top_ff} - {1'b0, bot_ff};
   assign mid_sum    = {1'b0, top_ff} + {1'b0, bot_ff} + (AW+1)'(1);
   assign mid        = mid_sum[AW:1];

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      sorted_in    = sorted_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      bot_in       = bot_ff;
      top_in       = top_ff;
      tmp_in       = tmp_ff;
      tmptag_in    = tmptag_ff;
      prev_in      = prev_ff;
      prevtag_in   = prevtag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_empty_in = rsp_empty_ff;
      we           = 1'b0;
      we_lane      = '0;
      waddr        = AW'(row_number);
      wdata_v      = {MAX_VARS{coord_value}};
      wdata_t      = row_number;
      raddr        = i_ff;
      sort_mode    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (store_ok) begin
               we = 1'b1;
               we_lane[coord_number] = 1'b1;
               if (CW'(row_number) >= count_ff) count_in = CW'(row_number) + CW'(1);
               sorted_in = 1'b0;
            end else if (acc && op == OP_LOOKUP) begin
               if (sorted_ff || count_ff < CW'(2)) begin
                  sorted_in = 1'b1;
                  state_in  = ST_CLAMP;
               end else begin
                  i_in     = AW'(1);
                  state_in = ST_SORT_RD_I;
               end
            end
         end
         // insertion sort: hold row i in tmp, shift larger rows up
         ST_SORT_RD_I: begin
            raddr    = i_ff;
            state_in = ST_SORT_WAIT_I;
         end
         ST_SORT_WAIT_I: begin
            tmp_in    = rdata_v;
            tmptag_in = rdata_t;
            j_in      = i_ff;
            state_in  = ST_SORT_RD_J;
         end
         ST_SORT_RD_J: begin
            raddr    = j_ff - AW'(1);
            state_in = ST_SORT_WAIT_J;
         end
         ST_SORT_WAIT_J: begin
            raddr    = j_ff - AW'(1);
            state_in = ST_SORT_CMP_J;
         end
         ST_SORT_CMP_J: begin
            sort_mode = 1'b1;
            if (row_gt) begin
               we      = 1'b1;
               we_lane = '1;
               waddr   = j_ff;
               wdata_v = rdata_v;
               wdata_t = rdata_t;
               j_in    = j_ff - AW'(1);
               state_in = (j_ff == AW'(1)) ? ST_SORT_PLACE : ST_SORT_RD_J;
            end else begin
               state_in = ST_SORT_PLACE;
            end
         end
         ST_SORT_PLACE: begin
            we      = 1'b1;
            we_lane = '1;
            waddr   = j_ff;
            wdata_v = tmp_ff;
            wdata_t = tmptag_ff;
            if (CW'(i_ff) + CW'(1) >= count_ff) begin
               sorted_in = 1'b1;
               state_in  = ST_CLAMP;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = ST_SORT_RD_I;
            end
         end
         ST_CLAMP: begin
            if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = '0;
               rsp_empty_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               bot_in   = '0;
               top_in   = AW'(count_ff - CW'(1));
               i_in     = '0;
               phase_in = PH_FIRST;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_RD;
            case (phase_ff)
               PH_FIRST: begin
                  if (!q_above) begin
                     rsp_row_in = rdata_t;
                     state_in   = ST_DONE;
                  end else begin
                     i_in     = top_ff;
                     phase_in = PH_LAST;
                  end
               end
               PH_LAST: begin
                  if (q_above) begin
                     rsp_row_in = rdata_t;
                     state_in   = ST_DONE;
                  end else if (span > (AW+1)'(LINEAR_SPAN)) begin
                     i_in     = bot_ff;
                     phase_in = PH_BIN_BOT;
                  end else begin
                     i_in     = bot_ff;
                     phase_in = PH_LIN;
                  end
               end
               PH_BIN_BOT: begin
                  if (q_equal) begin
                     rsp_row_in = rdata_t;
                     state_in   = ST_DONE;
                  end else begin
                     i_in     = top_ff;
                     phase_in = PH_BIN_TOP;
                  end
               end
               PH_BIN_TOP: begin
                  if (q_equal) begin
                     rsp_row_in = rdata_t;
                     state_in   = ST_DONE;
                  end else begin
                     i_in     = mid;
                     phase_in = PH_BIN_MID;
                  end
               end
               PH_BIN_MID: begin
                  if (q_above) bot_in = mid;
                  else top_in = mid;
                  if ((q_above ? ({1'b0, top_ff} - {1'b0, mid})
                               : ({1'b0, mid} - {1'b0, bot_ff}))
                      > (AW+1)'(LINEAR_SPAN)) begin
                     i_in     = q_above ? mid : bot_ff;
                     phase_in = PH_BIN_BOT;
                  end else begin
                     i_in     = q_above ? mid : bot_ff;
                     phase_in = PH_LIN;
                  end
               end
               PH_LIN: begin
                  // i runs while query above row i; stop at first row not below
                  if (q_above && i_ff != top_ff) begin
                     prev_in    = rdata_v;
                     prevtag_in = rdata_t;
                     i_in       = i_ff + AW'(1);
                  end else if (q_above) begin
                     // past top: never happens since query not above top row
                     rsp_row_in = rdata_t;
                     state_in   = ST_DONE;
                  end else if (i_ff == '0) begin
                     rsp_row_in = rdata_t;
                     state_in   = ST_DONE;
                  end else begin
                     phase_in = PH_NEAR;
                     state_in = ST_EVAL;
                     // row i still on rdata; fall into pair check next cycle
                  end
               end
               PH_NEAR: begin
                  rsp_row_in = upper_nearer ? rdata_t : prevtag_ff;
                  state_in   = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
            // prev row must be i-1 for the pair; linear scan starts at bottom
            // where query is above row bottom, so prev is loaded first.
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_empty_in = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (state_ff == ST_RD || state_ff == ST_WAIT) raddr = i_ff;
      if (state_ff == ST_EVAL) raddr = i_ff;
      if (do_clear) begin
         count_in  = '0;
         sorted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FIRST;
         vars_ff      <= CFG_W'(1);
         count_ff     <= '0;
         sorted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_VARS; i++) begin
            least_ff[i] <= 32'sh7fffffff;
            great_ff[i] <= 32'sh80000000;
            cq_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sorted_ff    <= sorted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr && csr_paddr == 2'(REG_VARS_IN_USE)) vars_ff <= csr_pwdata[CFG_W-1:0];
         if (do_clear) begin
            for (int i = 0; i < MAX_VARS; i++) begin
               least_ff[i] <= 32'sh7fffffff;
               great_ff[i] <= 32'sh80000000;
            end
         end else if (store_ok) begin
            for (int i = 0; i < MAX_VARS; i++) begin
               if (VAR_W'(i) == coord_number) begin
                  if (coord_value < least_ff[i]) least_ff[i] <= coord_value;
                  if (coord_value > great_ff[i]) great_ff[i] <= coord_value;
               end
            end
         end
         // raise to the minimum, then cap at the maximum
         if (state_ff == ST_CLAMP) begin
            for (int i = 0; i < MAX_VARS; i++) begin
               if (qin_ff[i] < least_ff[i])
                  cq_ff[i] <= (least_ff[i] > great_ff[i]) ? great_ff[i] : least_ff[i];
               else if (qin_ff[i] > great_ff[i]) cq_ff[i] <= great_ff[i];
               else cq_ff[i] <= qin_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      bot_ff     <= bot_in;
      top_ff     <= top_in;
      tmp_ff     <= tmp_in;
      tmptag_ff  <= tmptag_in;
      prev_ff    <= prev_in;
      prevtag_ff <= prevtag_in;
      rsp_row_ff <= rsp_row_in;
      rsp_empty_ff <= rsp_empty_in;
      if (acc && op == OP_LOOKUP) begin
         for (int i = 0; i < MAX_VARS; i++)
            qin_ff[i] <= (i < QL) ? query[i % NQ] : 32'sd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'(rsp_row_ff);
   assign rsp_tuser  = rsp_empty_ff;

   `SVNL_ASSERT_IMPL(a_ready_blocked, clock, reset, rsp_valid_ff |-> !req_tready)
   `SVNL_ASSERT_IMPL(a_count_range, clock, reset, 32'(count_ff) <= 32'(MAX_ROWS))
   `SVNL_ASSERT_IMPL(a_clear_empties, clock, reset, $past(do_clear) |-> count_ff == '0)
   `SVNL_ASSERT_IMPL(a_empty_zero, clock, reset, (rsp_valid_ff && rsp_empty_ff) |-> rsp_row_ff == '0)
endmodule
